[src/stsi_pkg.sv]
// Shared definitions for the sorted table insert/search core.
// Holds the request operation codes and the controller state type; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stsi_pkg;

    // Request operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Controller states of the search and insert sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_DECIDE,
        ST_SHIFT,
        ST_INSERT,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

[src/sorted_table_insert_search_core.sv]
// Top level of the sorted table insert/search core: sequencer, request and result registers.
// Depends on stsi_pkg and stsi_table_ram.
`timescale 1ns / 1ps
`default_nettype none

// The core keeps up to CAPACITY entries (a key and a data word each) in ascending
// unsigned key order in one synchronous table memory, plus a count of entries.
// Every request runs a binary search over the occupied entries and reports whether
// the key is present, its position or its insertion point, and its data when present.
// An insert request with an absent key and a table that is not full then moves the
// entries from the insertion point upward by one place and writes the new entry.
// Sequence: one request is in work at a time. Each probe of the search is a memory
// read, then a compare; there are at most ceil(log2(count+1)) probes, and a search
// that ends on an empty window passes the read state once more without a read.
// An insert then moves each entry from the insertion point upward, one at a time,
// and writes the new entry. Every request also passes through an accept state, a
// decision state and a result hand-off state. The single read and single write port
// of the table memory govern the shift: it reads one entry and writes the one above
// it in each cycle. A finished result waits in its own register, so the next request
// is accepted while the previous result is still unclaimed; that request then waits
// in the hand-off state until the previous result is taken.
// Reset empties the table by clearing the count; the memory itself needs no clearing
// pass, since only positions below the count are ever used.
module sorted_table_insert_search_core
    import stsi_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int KEY_BITS  = 64,
    parameter int DATA_BITS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request channel.
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_op,
    input  wire logic [KEY_BITS-1:0]             i_key,
    input  wire logic [DATA_BITS-1:0]            i_entry_data,
    // Result channel.
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_found,
    output logic [$clog2(CAPACITY+1)-1:0]        o_index,
    output logic                                 o_inserted,
    output logic [DATA_BITS-1:0]                 o_match_data,
    output logic [$clog2(CAPACITY+1)-1:0]        o_entry_count
);

    // Address width of the table and width of counts and positions (0..CAPACITY).
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = KEY_BITS + DATA_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Sequencer state and request registers.
    t_state               r_state, n_state;
    logic                 r_op, n_op;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_data, n_data;
    // Search window [lo, hi) and the probed position.
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi, n_hi;
    logic [AW-1:0]        r_mid, n_mid;
    // Search outcome.
    logic                 r_found, n_found;
    logic [CW-1:0]        r_pos, n_pos;
    logic [DATA_BITS-1:0] r_mdata, n_mdata;
    logic                 r_ins, n_ins;
    // Shift source position and entry count.
    logic [AW-1:0]        r_src, n_src;
    logic [CW-1:0]        r_count, n_count;

    // Table memory ports.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WW-1:0]        ram_rdata;

    // Probe address and the halves of the word read back.
    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid_a;
    logic [KEY_BITS-1:0]  rd_key;
    logic [DATA_BITS-1:0] rd_data;
    logic                 load_out;

    // Each entry is stored as one word with the key in the upper part.
    stsi_table_ram #(
        .ADDR_BITS (AW),
        .DEPTH     (CAPACITY),
        .WORD_BITS (WW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[DATA_BITS +: KEY_BITS];
    assign rd_data = ram_rdata[DATA_BITS-1:0];

    // The probe is (lo + hi - 1) / 2, which stays below hi and thus within the table.
    // It is only used while lo < hi, so hi is at least one.
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} - {{CW{1'b0}}, 1'b1};
    assign mid_a   = mid_sum[AW:1];

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_data    = r_data;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_found   = r_found;
        n_pos     = r_pos;
        n_mdata   = r_mdata;
        n_ins     = r_ins;
        n_src     = r_src;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        load_out  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_data  = i_entry_data;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_mdata = '0;
                    n_ins   = 1'b0;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    ram_raddr = mid_a;
                    n_mid     = mid_a;
                    n_state   = ST_CMP;
                end else begin
                    // Window is empty: lo is the insertion point.
                    n_pos   = r_lo;
                    n_state = ST_DECIDE;
                end
            end
            ST_CMP: begin
                if (r_key == rd_key) begin
                    n_found = 1'b1;
                    n_pos   = CW'(r_mid);
                    n_mdata = rd_data;
                    n_state = ST_DECIDE;
                end else begin
                    if (r_key < rd_key) begin
                        n_hi = CW'(r_mid);
                    end else begin
                        n_lo = CW'(r_mid) + CW'(1);
                    end
                    n_state = ST_SRCH;
                end
            end
            ST_DECIDE: begin
                if ((r_op == OP_INSERT) && !r_found && (r_count != CAP_C)) begin
                    if (r_count == r_pos) begin
                        n_state = ST_INSERT;
                    end else begin
                        // Start the shift with the topmost occupied entry.
                        ram_raddr = AW'(r_count - CW'(1));
                        n_src     = AW'(r_count - CW'(1));
                        n_state   = ST_SHIFT;
                    end
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SHIFT: begin
                // The entry read last cycle moves up one place; the next one down is read.
                ram_we    = 1'b1;
                ram_waddr = r_src + AW'(1);
                ram_wdata = ram_rdata;
                if (CW'(r_src) > r_pos) begin
                    ram_raddr = r_src - AW'(1);
                    n_src     = r_src - AW'(1);
                end else begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_pos);
                ram_wdata = {r_key, r_data};
                n_count   = r_count + CW'(1);
                n_ins     = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!o_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Request and search registers.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_key   <= n_key;
        r_data  <= n_data;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_mdata <= n_mdata;
        r_ins   <= n_ins;
        r_src   <= n_src;
    end

    // Result register: holds a finished result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_found       <= r_found;
            o_index       <= r_pos;
            o_inserted    <= r_ins;
            o_match_data  <= r_mdata;
            o_entry_count <= r_count;
        end
    end

endmodule

`default_nettype wire

[src/stsi_table_ram.sv]
// Single-clock table memory: one write port and one read port with registered read data.
// Stand-alone; used by sorted_table_insert_search_core.
`timescale 1ns / 1ps
`default_nettype none

module stsi_table_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WORD_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
